// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check prop at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that cond never holds at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== src/nidt_pkg.sv =====
// ---------------------------------------------------------------------------
// nidt_pkg
// Types and constants of the node identifier association table.
// ---------------------------------------------------------------------------
`default_nettype none

package nidt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int ID_W          = 32;

	localparam logic [ID_W-1:0] EMPTY_ID = {ID_W{1'b1}};

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] STATUS_NONE   = 2'd0;
	localparam logic [1:0] STATUS_VALID  = 2'd1;
	localparam logic [1:0] STATUS_FAILED = 2'd2;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [ID_W-1:0] node_id;
	} req_t;

	typedef struct packed {
		logic       success;
		logic [1:0] check_status;
	} rsp_t;

	// request as it walks down the row of slot cells
	typedef struct packed {
		logic            valid;
		logic [1:0]      cmd;
		logic [ID_W-1:0] id;
		logic            hit;
		logic            free_seen;
	} tok_t;

	// broadcast from the end of the row back to every cell
	typedef struct packed {
		logic            finish;
		logic            write;
		logic            clear;
		logic [ID_W-1:0] wr_id;
	} ctl_t;

endpackage

`default_nettype wire

// ===== src/nidt_cell.sv =====
// ---------------------------------------------------------------------------
// nidt_cell
// One identifier slot: compares the passing request, claims itself as the
// lowest free slot for an insert, and forwards the request one cell a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nidt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire nidt_pkg::tok_t tok_in,
	input  wire nidt_pkg::ctl_t ctl,
	output nidt_pkg::tok_t      tok_out,
	output logic                claim
);
	import nidt_pkg::*;

	logic [ID_W-1:0] slot_q;
	logic            claim_q;
	tok_t            tok_q;
	logic            match;
	logic            empty;

	assign match = (tok_in.id == slot_q);
	assign empty = (slot_q == EMPTY_ID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= EMPTY_ID;
			claim_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (ctl.clear) begin
				slot_q <= EMPTY_ID;
			end else if (ctl.write && claim_q) begin
				slot_q <= ctl.wr_id;
			end

			// claim only if no earlier cell was free
			if (ctl.finish) begin
				claim_q <= 1'b0;
			end else if (tok_in.valid && tok_in.cmd == CMD_INSERT && empty
					&& !tok_in.free_seen) begin
				claim_q <= 1'b1;
			end

			tok_q.valid     <= tok_in.valid;
			tok_q.cmd       <= tok_in.cmd;
			tok_q.id        <= tok_in.id;
			tok_q.hit       <= tok_in.hit | match;
			tok_q.free_seen <= tok_in.free_seen | empty;
		end
	end

	assign tok_out = tok_q;
	assign claim   = claim_q;

	`ASSERT_CLK(a_claim_empty, clk, arst_n, claim_q |-> (slot_q == EMPTY_ID), "claimed slot not empty")
	`ASSERT_CLK(a_claim_drop, clk, arst_n, ctl.finish |=> !claim_q, "claim held past finish")
	`ASSERT_NEVER(a_write_stray, clk, arst_n, ctl.write && !ctl.finish, "write outside finish")

endmodule

`default_nettype wire

// ===== src/node_id_association_table.sv =====
// ---------------------------------------------------------------------------
// node_id_association_table
// Table of node identifiers with insert, find, check and clear commands.
// ---------------------------------------------------------------------------
//   channel   handshake          payload             width
//   request   start / busy       req (cmd, node_id)  2 + 32
//   result    done (strobe)      rsp (success,       1 + 2
//                                     check_status)
//   config    cfg_we             cfg_wdata           1 (table_enabled)
//
// Each request walks the row of TABLE_ENTRIES slot cells, one cell a cycle,
// collecting "present" and "free slot seen"; the lowest empty cell marks a
// claim on the way. When the request leaves the last cell, the end stage
// commits the insert or clear and registers the result.
// A request passes the launch register, the row of cells and the done
// register on its way from start to the done strobe; busy is high until
// it leaves the row, and a new start is taken in the cycle done is shown.
// Reset empties every slot and clears table_enabled; no clearing pass.
// Results are not stalled: done lasts one cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module node_id_association_table (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire nidt_pkg::req_t req,
	output logic                done,
	output nidt_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);
	import nidt_pkg::*;

	tok_t                     tok [TABLE_ENTRIES+1];
	tok_t                     tok0_q;
	ctl_t                     ctl;
	logic [TABLE_ENTRIES-1:0] claims;
	logic [TABLE_ENTRIES:0]   tok_valids;
	logic                     busy_q;
	logic                     done_q;
	rsp_t                     rsp_q;
	logic                     enabled_q;
	logic                     accept;
	tok_t                     tail;
	rsp_t                     rsp_d;

	assign accept = start && !busy_q;
	assign tok[0] = tok0_q;
	assign tail   = tok[TABLE_ENTRIES];

	// launch register: hand the request to the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.valid     <= accept;
			tok0_q.cmd       <= req.cmd;
			tok0_q.id        <= req.node_id;
			tok0_q.hit       <= 1'b0;
			tok0_q.free_seen <= 1'b0;
		end
	end

	// row of slot cells
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		nidt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[k]),
			.ctl     (ctl),
			.tok_out (tok[k+1]),
			.claim   (claims[k])
		);
	end

	for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_valid
		assign tok_valids[k] = tok[k].valid;
	end

	// end of the row: commit the insert or clear back into the cells
	always_comb begin
		ctl.finish = tail.valid;
		ctl.write  = tail.valid && tail.cmd == CMD_INSERT && !tail.hit && tail.free_seen;
		ctl.clear  = tail.valid && tail.cmd == CMD_CLEAR;
		ctl.wr_id  = tail.id;
	end

	// result of the request leaving the row
	always_comb begin
		rsp_d = '0;
		case (tail.cmd)
			CMD_INSERT: rsp_d.success = tail.hit | tail.free_seen;
			CMD_FIND:   rsp_d.success = !enabled_q | tail.hit;
			CMD_CHECK: begin
				if (!enabled_q) begin
					rsp_d.check_status = STATUS_NONE;
				end else if (tail.id == EMPTY_ID || tail.hit) begin
					rsp_d.check_status = STATUS_VALID;
				end else begin
					rsp_d.check_status = STATUS_FAILED;
				end
			end
			CMD_CLEAR:  rsp_d.success = 1'b1;
			default:    rsp_d = '0;
		endcase
	end

	// hold busy from accept until the request leaves the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			rsp_q <= rsp_d;
		end
	end

	// table_enabled register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_CLK(a_one_claim, clk, arst_n, $onehot0(claims), "more than one slot claimed")
	`ASSERT_CLK(a_one_req, clk, arst_n, $onehot0(tok_valids), "more than one request in row")
	`ASSERT_CLK(a_accept_busy, clk, arst_n, accept |=> busy_q, "busy not raised on accept")
	`ASSERT_CLK(a_done_idle, clk, arst_n, done_q |-> !busy_q, "done while still busy")

endmodule

`default_nettype wire

// ===== tb/tb_node_id_association_table.sv =====
// ---------------------------------------------------------------------------
// tb_node_id_association_table
// Self-checking bench for the node identifier table: drive insert, find,
// check and clear requests through start/busy, mirror the slot contents and
// the enable bit in a scoreboard, and compare every done strobe in order.
// ---------------------------------------------------------------------------
module tb_node_id_association_table;
	timeunit 1ns;
	timeprecision 1ps;

	import nidt_pkg::*;

	// idle cycles with no request taken and no result before giving up;
	// the slowest correct wait is the longest sender gap plus one table walk
	localparam int STALL_LIMIT  = 1000;
	localparam int POOL_SIZE    = 24;
	localparam int PHASE_ITEMS  = 250;
	localparam int PHASE_COUNT  = 5;

	// -----------------------------------------------------------------------
	// Scoreboard: shadow copy of the slots and the enable bit, plus the queue
	// of responses still owed by the block.
	// -----------------------------------------------------------------------
	class table_scoreboard;
		logic [ID_W-1:0] shadow_slots [TABLE_ENTRIES];
		logic            shadow_enabled;
		rsp_t            expected_rsp_q [$];
		int              errors;

		function new();
			foreach (shadow_slots[k])
				shadow_slots[k] = EMPTY_ID;
			shadow_enabled = 1'b0;
			errors = 0;
		endfunction

		// work out the response of one request and advance the shadow table
		function rsp_t predict_table_response(req_t r);
			rsp_t o;
			bit   present;
			int   free_idx;
			o = '0;
			present = 1'b0;
			free_idx = -1;
			foreach (shadow_slots[k]) begin
				if (shadow_slots[k] == r.node_id)
					present = 1'b1;
				if (free_idx < 0 && shadow_slots[k] == EMPTY_ID)
					free_idx = k;
			end
			case (r.cmd)
				CMD_INSERT: begin
					// an all-ones id "matches" any empty slot, so nothing is written
					if (present) begin
						o.success = 1'b1;
					end else if (free_idx >= 0) begin
						shadow_slots[free_idx] = r.node_id;
						o.success = 1'b1;
					end
				end
				CMD_FIND: begin
					o.success = !shadow_enabled || present;
				end
				CMD_CHECK: begin
					if (!shadow_enabled)
						o.check_status = STATUS_NONE;
					else if (r.node_id == EMPTY_ID || present)
						o.check_status = STATUS_VALID;
					else
						o.check_status = STATUS_FAILED;
				end
				default: begin
					// clear empties the slots and leaves the enable bit alone
					foreach (shadow_slots[k])
						shadow_slots[k] = EMPTY_ID;
					o.success = 1'b1;
				end
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			expected_rsp_q.push_back(predict_table_response(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: result with nothing outstanding: success %0d status %0d",
					$realtime, got.success, got.check_status);
				errors++;
				return;
			end
			want = expected_rsp_q.pop_front();
			if (got.success !== want.success) begin
				$display("%0t: success mismatch: expected %0d actual %0d",
					$realtime, want.success, got.success);
				errors++;
			end
			if (got.check_status !== want.check_status) begin
				$display("%0t: check_status mismatch: expected %0d actual %0d",
					$realtime, want.check_status, got.check_status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic cfg_wdata;

	table_scoreboard sb;
	bit              no_idle;
	int              stall_cycles;

	node_id_association_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Monitor: sample the handshakes at the rising edge. A request is taken
	// when start is high and busy low; a result exists only while done is up.
	// Also run the stall watchdog here.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req);
			if (done)
				sb.check_result(rsp);
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Driver tasks. Each is entered and left at a falling edge.
	// -----------------------------------------------------------------------

	// Present one request and hold it until the block takes it. Now and then
	// drop start for a random gap first so idles land on every cell of the walk.
	task automatic send_request(input logic [1:0] c, input logic [ID_W-1:0] id);
		int gap;
		if (!no_idle && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			gap = $urandom_range(1, 20);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= '{cmd: c, node_id: id};
		// busy only moves at the rising edge, so its value here decides the take
		while (busy)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Drop start and wait until every owed response has come back.
	task automatic drain_requests();
		start <= 1'b0;
		while (sb.expected_rsp_q.size() != 0)
			@(negedge clk);
	endtask

	// Write table_enabled; only called with the block idle.
	task automatic write_enable(input logic value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.shadow_enabled = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		logic [ID_W-1:0] id_pool [POOL_SIZE];
		logic [ID_W-1:0] id;
		logic [1:0]      c;
		int              roll;

		sb = new();
		stall_cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;

		// hold reset low, then release it on a falling edge
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed: table disabled after reset ---
		send_request(CMD_FIND, 32'h1234_5678);     // disabled find passes
		send_request(CMD_CHECK, EMPTY_ID);         // disabled check answers none
		send_request(CMD_INSERT, 32'h0000_0000);   // insert still stores when disabled
		send_request(CMD_INSERT, EMPTY_ID);        // all ones matches an empty slot
		drain_requests();
		write_enable(1'b1);

		// --- directed: table enforced ---
		send_request(CMD_CHECK, EMPTY_ID);         // broadcast is always valid
		send_request(CMD_CHECK, 32'hDEAD_BEEF);    // absent id fails
		send_request(CMD_FIND, 32'hDEAD_BEEF);     // absent id misses
		send_request(CMD_FIND, EMPTY_ID);          // hits while a slot is empty
		// fill the remaining 15 slots
		send_request(CMD_INSERT, 32'h8000_0000);
		send_request(CMD_INSERT, 32'h7FFF_FFFF);
		send_request(CMD_INSERT, 32'hFFFF_FFFE);
		for (int k = 0; k < TABLE_ENTRIES - 4; k++)
			send_request(CMD_INSERT, 32'h0000_0100 + k);
		send_request(CMD_INSERT, 32'hCAFE_F00D);   // full table: absent insert fails
		send_request(CMD_FIND, EMPTY_ID);          // full table: all ones misses
		send_request(CMD_INSERT, EMPTY_ID);        // full table: all ones fails too
		send_request(CMD_CLEAR, 32'h0000_0000);
		send_request(CMD_FIND, 32'h8000_0000);     // cleared, and enable is kept
		drain_requests();

		// --- random phases, alternating the enable bit ---
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_enable(p[0] ? 1'b0 : 1'b1);
			// keep the second phase free of sender gaps
			no_idle = (p == 1);
			// small id pool so hits, duplicates and a full table all show up
			foreach (id_pool[k])
				id_pool[k] = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 37)
					c = CMD_INSERT;
				else if (roll < 62)
					c = CMD_FIND;
				else if (roll < 99)
					c = CMD_CHECK;
				else
					c = CMD_CLEAR;
				roll = $urandom_range(0, 99);
				if (roll < 6)
					id = EMPTY_ID;
				else if (roll < 80)
					id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					id = $urandom;
				send_request(c, id);
			end
			// pause until every response of the phase is in
			drain_requests();
		end

		// let one more table walk go by in case of a stray strobe
		repeat (TABLE_ENTRIES + 4) @(negedge clk);

		if (sb.errors == 0 && sb.expected_rsp_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
